// ===== sv/kpd_pkg.sv =====
// Shared constants and types for the 4x4 keypad scanner with debounce.
package kpd_pkg;

	localparam int KPD_ROWS         = 4;
	localparam int KPD_COLS         = 4;
	localparam int KPD_KEYS         = KPD_ROWS * KPD_COLS;
	localparam int KPD_HISTORY_BITS = 8;

	// Register map: register index taken from the word address bit.
	localparam int KPD_PADDR_W      = 3;
	localparam logic KPD_REG_LEVEL_MODE = 1'b0;

	typedef enum logic {
		CMD_SCAN  = 1'b0,
		CMD_CLEAR = 1'b1
	} kpd_cmd_t;

endpackage

// ===== sv/kpd_row_update.sv =====
// Debounce update for the four keys of the row that is being scanned.
module kpd_row_update
	import kpd_pkg::*;
#(
	parameter int HISTORY_BITS = KPD_HISTORY_BITS
) (
	input  logic                             level_mode,
	input  logic [KPD_COLS-1:0]              column_levels,
	input  logic [KPD_COLS*HISTORY_BITS-1:0] hist_row,
	input  logic [KPD_COLS-1:0]              status_row,
	output logic [KPD_COLS*HISTORY_BITS-1:0] hist_row_next,
	output logic [KPD_COLS-1:0]              status_row_next
);

	genvar c;
	generate
		for (c = 0; c < KPD_COLS; c++) begin : g_key
			logic [HISTORY_BITS-1:0] shifted;
			logic                    pressed;

			assign shifted = {hist_row[c*HISTORY_BITS +: HISTORY_BITS-1], column_levels[c]};
			assign pressed = (shifted == '0);

			always_comb begin
				hist_row_next[c*HISTORY_BITS +: HISTORY_BITS] = shifted;
				status_row_next[c] = status_row[c];
				if (level_mode) begin
					status_row_next[c] = pressed;
				end else if (pressed) begin
					// A latched press refills the history so a held key fires again later.
					status_row_next[c] = 1'b1;
					hist_row_next[c*HISTORY_BITS +: HISTORY_BITS] = '1;
				end
			end
		end
	endgenerate

endmodule

// ===== sv/kpd_cfg_regs.sv =====
// Configuration register block on an APB-style port.
module kpd_cfg_regs
	import kpd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [KPD_PADDR_W-1:0] paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	output logic                   level_mode
);

	logic level_mode_q;
	logic reg_sel;

	assign pready     = 1'b1;
	assign reg_sel    = (paddr[2] == KPD_REG_LEVEL_MODE);
	assign level_mode = level_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			level_mode_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata[0] = level_mode_q;
		end
	end

endmodule

// ===== sv/keypad_4x4_scan_debounce_unit.sv =====
// Top level of the 4x4 keypad scanner with shift-register debounce.
//
// The block scans a 4x4 active-low key matrix. Each input word is either a scan tick carrying
// the four column levels of the row currently driven low, or a clear command that removes one
// status bit. A scan tick shifts each column level into that key's HISTORY_BITS-deep sample
// history; a key whose whole history is zero counts as pressed. With level_mode at 0 a press
// sets a sticky event bit and refills the history with ones, so a held key fires again every
// HISTORY_BITS scans of its row; with level_mode at 1 the status bit follows the debounced
// level. After each scan tick the next row is driven low. Every input word yields exactly one
// output word with the full status, the row drive pattern and the row to be sampled next.
// Throughput is one word per clock cycle while the output side takes results; a word passes
// through the input register and the result register, with the single row update between them.
// While a finished result waits for the output side, the input register can still take one
// more word; after that the input side stalls until the output side takes the result.
// level_mode sits at byte address 0 of the APB port and should only change while idle.
module keypad_4x4_scan_debounce_unit
	import kpd_pkg::*;
#(
	parameter int HISTORY_BITS = KPD_HISTORY_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,  // [3:0] column_levels, [7:4] clear_index
	input  logic                   s_axis_tuser,  // [0] command

	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [23:0]            m_axis_tdata,  // [15:0] key_status, [19:16] row_drive,
	                                              // [21:20] next_row, [23:22] zero

	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [KPD_PADDR_W-1:0] paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int ROW_HIST_W = KPD_COLS * HISTORY_BITS;

	logic level_mode;

	// Input register stage.
	logic                valid_s1;
	kpd_cmd_t            cmd_s1;
	logic [KPD_COLS-1:0] cols_s1;
	logic [3:0]          idx_s1;

	// Architectural state.
	logic [ROW_HIST_W-1:0] hist_q [KPD_ROWS];
	logic [KPD_KEYS-1:0]   status_q;
	logic [1:0]            row_q;

	// Result register.
	logic                  out_valid_q;
	logic [KPD_KEYS-1:0]   out_status_q;
	logic [KPD_ROWS-1:0]   out_drive_q;
	logic [1:0]            out_row_q;

	logic                  advance;
	logic [ROW_HIST_W-1:0] hist_row_next;
	logic [KPD_COLS-1:0]   status_row_next;
	logic [KPD_KEYS-1:0]   status_new;
	logic [1:0]            row_new;

	kpd_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.level_mode (level_mode)
	);

	kpd_row_update #(
		.HISTORY_BITS (HISTORY_BITS)
	) u_row (
		.level_mode      (level_mode),
		.column_levels   (cols_s1),
		.hist_row        (hist_q[row_q]),
		.status_row      (status_q[{row_q, 2'b00} +: KPD_COLS]),
		.hist_row_next   (hist_row_next),
		.status_row_next (status_row_next)
	);

	// The word in the input register moves on once the result register is free or draining.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_comb begin
		status_new = status_q;
		row_new    = row_q;
		case (cmd_s1)
			CMD_CLEAR: begin
				status_new[idx_s1] = 1'b0;
			end
			CMD_SCAN: begin
				status_new[{row_q, 2'b00} +: KPD_COLS] = status_row_next;
				row_new = row_q + 2'd1;
			end
			default: begin
				status_new = status_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= kpd_cmd_t'(s_axis_tuser);
			cols_s1 <= s_axis_tdata[3:0];
			idx_s1  <= s_axis_tdata[7:4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < KPD_ROWS; r++) begin
				hist_q[r] <= '1;
			end
			status_q <= '0;
			row_q    <= 2'd0;
		end else if (advance) begin
			if (cmd_s1 == CMD_SCAN) begin
				hist_q[row_q] <= hist_row_next;
			end
			status_q <= status_new;
			row_q    <= row_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_status_q <= status_new;
			out_drive_q  <= ~(4'b0001 << row_new);
			out_row_q    <= row_new;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_row_q, out_drive_q, out_status_q};

`ifndef SYNTHESIS
	a_row_steps_on_scan: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (cmd_s1 == CMD_SCAN) |=> row_q == $past(row_q) + 2'd1)
		else $error("row index did not step after a scan tick");

	a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(row_q) && $stable(status_q))
		else $error("scanner state changed without a word moving on");

	a_clear_removes_bit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (cmd_s1 == CMD_CLEAR) |=> status_q[$past(idx_s1)] == 1'b0)
		else $error("clear command left its status bit set");

	a_clear_keeps_row: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (cmd_s1 == CMD_CLEAR) |=> $stable(row_q))
		else $error("clear command moved the scanned row");

	a_stalled_word_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input register dropped a word that did not move on");
`endif

endmodule

// ===== tb/tb_keypad_4x4_scan_debounce_unit.sv =====
// Self-checking testbench for the 4x4 keypad scanner with shift-register debounce.
module tb_keypad_4x4_scan_debounce_unit;
	import kpd_pkg::*;

	// The register map takes the register index from the word address bit, so level_mode
	// sits at byte address zero.
	localparam logic [KPD_PADDR_W-1:0] LEVEL_MODE_ADDR = {KPD_REG_LEVEL_MODE, 2'b00};
	localparam int HB            = KPD_HISTORY_BITS;
	localparam int HOLD_CYCLES   = 60;   // long receiver hold-off, fills the block
	localparam int SETTLE_CYCLES = 4;    // margin after the last output word
	localparam int STALL_LIMIT   = 5000; // cycles without any transfer before giving up

	// One input word as the stimulus sees it.
	typedef struct {
		kpd_cmd_t   cmd;
		logic [3:0] cols;
		logic [3:0] idx;
	} key_word_t;

	// One output word split into its fields.
	typedef struct {
		logic [15:0] key_status;
		logic [3:0]  row_drive;
		logic [1:0]  next_row;
	} scan_view_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata  = '0; // [3:0] column_levels, [7:4] clear_index
	logic              s_axis_tuser  = CMD_SCAN; // [0] command
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [23:0]       m_axis_tdata; // [15:0] key_status, [19:16] row_drive, [21:20] next_row
	logic              psel          = 1'b0;
	logic              penable       = 1'b0;
	logic              pwrite        = 1'b0;
	logic [KPD_PADDR_W-1:0] paddr    = '0;
	logic [31:0]       pwdata        = '0;
	logic [31:0]       prdata;
	logic              pready;

	keypad_4x4_scan_debounce_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #5 clk = ~clk;

	// Words waiting to be offered, and the status views the block owes us, oldest first.
	key_word_t  words_pending[$];
	scan_view_t views_due[$];

	// Our own copy of the scanner: per-key sample histories, status bits, row and mode.
	logic [HB-1:0] key_hist[KPD_KEYS];
	logic [15:0]   key_bits  = '0;
	logic [1:0]    scan_row  = '0;
	logic          level_on  = 1'b0;

	// Row that the stimulus believes is driven, advanced once per scan word queued.
	logic [1:0]    gen_row   = '0;

	int unsigned send_gap_pct   = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_requests  = 0;
	int unsigned hold_served    = 0;
	int unsigned mismatches     = 0;
	int unsigned words_checked  = 0;
	int unsigned scans_sent     = 0;
	int unsigned clears_sent    = 0;
	int unsigned bits_raised    = 0;
	int unsigned idle_cycles    = 0;

	initial begin
		for (int k = 0; k < KPD_KEYS; k++) key_hist[k] = '1;
	end

	// Applies one accepted word to the local copy of the scanner and returns the
	// status view that the block must answer with.
	function automatic scan_view_t advance_keypad(kpd_cmd_t cmd, logic [3:0] cols,
	                                              logic [3:0] idx);
		logic [HB-1:0] h;
		logic [15:0]   was;
		int            key;
		scan_view_t    v;
		was = key_bits;
		if (cmd == CMD_CLEAR) begin
			// A clear only drops the one named bit; histories and row stay put.
			key_bits[idx] = 1'b0;
		end else begin
			for (int c = 0; c < KPD_COLS; c++) begin
				key = int'(scan_row) * KPD_COLS + c;
				h = {key_hist[key][HB-2:0], cols[c]};
				if (level_on) begin
					key_bits[key] = (h == '0);
				end else if (h == '0) begin
					// Latched press: set the event and refill, so a held key fires again
					// after another full history of scans of its row.
					key_bits[key] = 1'b1;
					h = '1;
				end
				key_hist[key] = h;
			end
			scan_row = scan_row + 2'd1;
		end
		bits_raised += $countones(key_bits & ~was);
		v.key_status = key_bits;
		v.row_drive  = ~(4'b0001 << scan_row);
		v.next_row   = scan_row;
		return v;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned want,
	                               input int unsigned got);
		$display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
		mismatches++;
	endtask

	// Sender: offers queued words, idling at random, and predicts every accepted word.
	always @(posedge clk or negedge arst_n) begin
		key_word_t  w;
		scan_view_t v;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= CMD_SCAN;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				v = advance_keypad(kpd_cmd_t'(s_axis_tuser), s_axis_tdata[3:0],
				                   s_axis_tdata[7:4]);
				views_due.push_back(v);
				if (kpd_cmd_t'(s_axis_tuser) == CMD_CLEAR) clears_sent++;
				else scans_sent++;
			end
			// Only move on once the current word is gone; valid stays high while stalled.
			if (!s_axis_tvalid || s_axis_tready) begin
				if (words_pending.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
					w = words_pending.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {w.idx, w.cols};
					s_axis_tuser  <= w.cmd;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each accepted word against the oldest due view and stalls at
	// random. A hold-off request makes it refuse words for a long stretch that it counts
	// itself.
	always @(posedge clk or negedge arst_n) begin
		scan_view_t due;
		int         hold_left;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (views_due.size() == 0) begin
					report_mismatch("word with nothing due", 0, m_axis_tdata);
				end else begin
					due = views_due.pop_front();
					if (m_axis_tdata[15:0] !== due.key_status)
						report_mismatch("key_status", due.key_status, m_axis_tdata[15:0]);
					if (m_axis_tdata[19:16] !== due.row_drive)
						report_mismatch("row_drive", due.row_drive, m_axis_tdata[19:16]);
					if (m_axis_tdata[21:20] !== due.next_row)
						report_mismatch("next_row", due.next_row, m_axis_tdata[21:20]);
					words_checked++;
				end
			end
			if (hold_served != hold_requests) begin
				hold_left = HOLD_CYCLES;
				hold_served++;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: a run that stops moving words or register writes for too long has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("[%0t] no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic push_word(input kpd_cmd_t cmd, input logic [3:0] cols,
	                         input logic [3:0] idx);
		key_word_t w;
		w.cmd  = cmd;
		w.cols = cols;
		w.idx  = idx;
		words_pending.push_back(w);
		if (cmd == CMD_SCAN) gen_row = gen_row + 2'd1;
	endtask

	// The scan word for the row about to be sampled when the keys in held are down.
	function automatic logic [3:0] cols_for(input logic [15:0] held);
		return ~held[gen_row*4 +: 4];
	endfunction

	// Random traffic, mostly keys held long enough to pass the debounce (with the odd
	// bounce and clears mixed in), the rest noise and presses released too early.
	task automatic queue_press_traffic(input int unsigned count);
		int unsigned   queued;
		int unsigned   len;
		int unsigned   kind;
		logic [15:0]   held;
		logic [3:0]    cols;
		queued = 0;
		while (queued < count) begin
			kind = $urandom_range(9);
			if (kind < 7) begin
				case ($urandom_range(2))
					0:       held = $urandom & $urandom & $urandom;
					1:       held = $urandom;
					default: held = 16'hFFFF;
				endcase
				len = $urandom_range(20, 70);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(15) == 0) begin
						push_word(CMD_CLEAR, $urandom, $urandom);
					end else begin
						cols = cols_for(held);
						if ($urandom_range(19) == 0) cols ^= 4'b0001 << $urandom_range(3);
						push_word(CMD_SCAN, cols, $urandom);
					end
				end
				// Add up to three clears of random keys so latched events come back down.
				for (int i = $urandom_range(3); i > 0; i--) begin
					push_word(CMD_CLEAR, $urandom, $urandom);
					len++;
				end
				queued += len;
			end else if (kind < 9) begin
				len = $urandom_range(4, 16);
				for (int i = 0; i < len; i++)
					push_word($urandom_range(1) ? CMD_CLEAR : CMD_SCAN, $urandom, $urandom);
				queued += len;
			end else begin
				// Press released before the history runs out of ones.
				held = $urandom;
				len = $urandom_range(3, 20);
				for (int i = 0; i < len; i++) push_word(CMD_SCAN, cols_for(held), $urandom);
				queued += len;
			end
		end
	endtask

	// Waits until every queued word is in and every due view is out, then lets the
	// pipeline settle.
	task automatic wait_drained;
		do @(negedge clk);
		while (words_pending.size() != 0 || s_axis_tvalid || views_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Two-phase register write; the register takes the value at the access edge.
	task automatic write_level_mode(input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= LEVEL_MODE_ADDR;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		level_on = value[0];
		@(negedge clk);
	endtask

	// Sets the idling of both sides, writes the mode while the block is idle, queues the
	// traffic and waits for the block to answer all of it.
	task automatic run_phase(input logic [31:0] mode_value, input int unsigned gap_pct,
	                         input int unsigned stall_pct, input int unsigned count,
	                         input bit with_hold);
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		write_level_mode(mode_value);
		queue_press_traffic(count);
		if (with_hold) hold_requests++;
		wait_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening in latched mode: column extremes, both commands, a clear_index
		// that a scan must ignore and column levels that a clear must ignore, and clears
		// of the first and last key.
		send_gap_pct   = 10;
		recv_stall_pct = 56;
		write_level_mode(32'h0000_0000);
		push_word(CMD_SCAN,  4'hF, 4'h0);
		push_word(CMD_SCAN,  4'h0, 4'hF);
		push_word(CMD_SCAN,  4'h5, 4'hA);
		push_word(CMD_SCAN,  4'hA, 4'h5);
		push_word(CMD_CLEAR, 4'h0, 4'h0);
		push_word(CMD_CLEAR, 4'hF, 4'hF);
		push_word(CMD_SCAN,  4'h0, 4'h0);
		push_word(CMD_CLEAR, 4'h3, 4'h5);
		push_word(CMD_SCAN,  4'hF, 4'hF);
		push_word(CMD_CLEAR, 4'hC, 4'hA);
		wait_drained();

		// Mode switches keep histories and status, so each phase starts from what the
		// last one left. Wide values check that only bit zero counts.
		run_phase(32'h0000_0000, 10, 56, 430, 1'b1);
		run_phase(32'h0000_0001, 10, 56, 450, 1'b0);
		run_phase(32'hFFFF_FFFE, 56, 10, 450, 1'b0);
		run_phase(32'hFFFF_FFFF, 56, 10, 300, 1'b1);
		run_phase(32'h0000_0002,  0,  0, 260, 1'b1);

		$display("Covered %0d scan ticks and %0d clears in latched and level mode,",
		         scans_sent, clears_sent);
		$display("%0d output words checked, %0d key status bits raised along the way.",
		         words_checked, bits_raised);
		if (mismatches == 0 && views_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
